// ===== rtl/fa_tlb_pkg.sv =====
// types and codes shared by the translation buffer modules
`default_nettype none

package fa_tlb_pkg;

  localparam int unsigned PageW  = 36;
  localparam int unsigned EntryW = 32;
  localparam int unsigned OpW    = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [PageW-1:0]  virt_page;
    logic [EntryW-1:0] entry_in;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [EntryW-1:0] entry_out;
    logic              evicted;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fa_tlb_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module fa_tlb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     en_i,
  input  wire logic                                     we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fa_tlb_ctrl.sv =====
// handshake and sequencing state machine
`default_nettype none

module fa_tlb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fa_tlb_pkg::dp_cmd_t cmd_o
);

  import fa_tlb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_RESP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.exec    = (state_q == ST_EXEC);

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("execute cycle not followed by result");

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !cmd_o.capture)
    else $error("word accepted during execute");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && !cmd_o.exec))
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== rtl/fa_tlb_dp.sv =====
// tag cam, recency matrix, valid bits and entry ram
`default_nettype none

module fa_tlb_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fa_tlb_pkg::dp_cmd_t  cmd_i,
  input  wire fa_tlb_pkg::in_word_t in_word_i,
  output fa_tlb_pkg::out_word_t     out_word_o
);

  import fa_tlb_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [OpW-1:0]     op_q;
  logic [PageW-1:0]   page_q;
  logic [EntryW-1:0]  word_q;
  logic [PageW-1:0]   tag_q [ENTRIES];
  logic [ENTRIES-1:0] slot_valid_q;
  // mr_q[i][j] set: slot i is more recent than slot j
  logic [ENTRIES-1:0] mr_q [ENTRIES];
  logic [ENTRIES-1:0] mr_d [ENTRIES];
  logic [ENTRIES-1:0] col  [ENTRIES];
  logic               hit_q, evict_q;

  logic [ENTRIES-1:0] match, best_oh, victim_oh, sel_oh;
  logic [IdxW-1:0]    best_idx, victim_idx;
  logic               is_lookup, is_add, is_flush, any_hit, upd;
  logic [EntryW-1:0]  rdata;

  assign is_lookup = (op_q == OP_LOOKUP);
  assign is_add    = (op_q == OP_ADD);
  assign is_flush  = (op_q == OP_FLUSH);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = slot_valid_q[i] && (tag_q[i] == page_q);
      for (int j = 0; j < ENTRIES; j++) begin
        col[i][j] = mr_q[j][i];
      end
    end
  end

  always_comb begin
    best_oh    = '0;
    victim_oh  = '0;
    best_idx   = '0;
    victim_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      best_oh[i]   = match[i] && !(|(match & col[i]));
      victim_oh[i] = &(col[i] | (ENTRIES'(1) << i));
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (best_oh[i])   best_idx   = best_idx   | IdxW'(i);
      if (victim_oh[i]) victim_idx = victim_idx | IdxW'(i);
    end
  end

  assign any_hit = |match;
  assign upd     = cmd_i.exec && ((is_lookup && any_hit) || is_add);
  assign sel_oh  = is_add ? victim_oh : best_oh;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      mr_d[i] = mr_q[i];
    end
    if (cmd_i.exec && is_flush) begin
      for (int i = 0; i < ENTRIES; i++) begin
        for (int j = 0; j < ENTRIES; j++) begin
          mr_d[i][j] = (i < j);
        end
      end
    end else if (upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (i != j) begin
            if (sel_oh[i]) begin
              mr_d[i][j] = 1'b1;
            end else if (sel_oh[j]) begin
              mr_d[i][j] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        for (int j = 0; j < ENTRIES; j++) begin
          mr_q[i][j] <= (i < j);
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        mr_q[i] <= mr_d[i];
      end
      if (cmd_i.exec && is_flush) begin
        slot_valid_q <= '0;
      end else if (cmd_i.exec && is_add) begin
        slot_valid_q <= slot_valid_q | victim_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_word_i.opcode;
      page_q <= in_word_i.virt_page;
      word_q <= in_word_i.entry_in;
    end
    if (cmd_i.exec) begin
      hit_q   <= is_lookup && any_hit;
      evict_q <= is_add && (|(victim_oh & slot_valid_q));
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_add && victim_oh[i]) tag_q[i] <= page_q;
      end
    end
  end

  fa_tlb_ram #(
    .Width(EntryW),
    .Depth(ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .en_i   (upd),
    .we_i   (is_add),
    .addr_i (is_add ? victim_idx : best_idx),
    .wdata_i(word_q),
    .rdata_o(rdata)
  );

  assign out_word_o.hit       = hit_q;
  assign out_word_o.entry_out = hit_q ? rdata : '0;
  assign out_word_o.evicted   = evict_q;

  a_victim_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(victim_oh))
    else $error("recency order lost its least recent slot");

  a_best_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(best_oh) && (any_hit == (|best_oh)))
    else $error("hit select not unique");

  a_invalid_is_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|(victim_oh & slot_valid_q)) |-> (&slot_valid_q))
    else $error("valid slot chosen while an empty slot exists");

  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_add) |=> (|(slot_valid_q & $past(victim_oh))))
    else $error("added slot not marked valid");

endmodule

`default_nettype wire

// ===== rtl/fully_associative_lru_tlb_top.sv =====
// fully associative translation buffer with lru replacement, top level
//
//   channel   direction  handshake                 word
//   in        sink       in_valid_i / in_ready_o   fa_tlb_pkg::in_word_t
//   out       source     out_valid_o / out_ready_i fa_tlb_pkg::out_word_t
//
// a word is accepted, then executed (parallel tag compare and recency update),
// and its result is valid the cycle after, once the entry ram read has landed.
// a new word is accepted in the cycle its predecessor's result is taken, so the
// block holds one word at a time.
// reset clears the valid bits and restores slot order at once, no sweep.
// a stalled result holds its word and blocks new input until taken.
`default_nettype none

module fully_associative_lru_tlb_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire fa_tlb_pkg::in_word_t in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output fa_tlb_pkg::out_word_t     out_word_o
);

  import fa_tlb_pkg::*;

  dp_cmd_t cmd;

  fa_tlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  fa_tlb_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .out_word_o(out_word_o)
  );

endmodule

`default_nettype wire

// ===== sim/fully_associative_lru_tlb_checker.sv =====
// checker for the lru translation buffer: models each accepted word and compares its result
`timescale 1ns / 1ps

module fully_associative_lru_tlb_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  fa_tlb_pkg::in_word_t  in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  fa_tlb_pkg::out_word_t out_word_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  import fa_tlb_pkg::*;

  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [PageW-1:0]  tag_mem [ENTRIES];
  logic [EntryW-1:0] word_mem[ENTRIES];
  logic              live    [ENTRIES];
  logic [RankW-1:0]  lru_rank[ENTRIES];

  out_word_t awaited_results[$];

  function automatic void promote_slot(int slot);
    logic [RankW-1:0] old_rank;
    old_rank = lru_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (lru_rank[i] < old_rank) lru_rank[i] = lru_rank[i] + 1'b1;
    end
    lru_rank[slot] = '0;
  endfunction

  function automatic out_word_t translate_word(in_word_t w);
    out_word_t res;
    int        best;
    int        victim;
    res = '0;
    case (w.opcode)
      OP_LOOKUP: begin
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i] && tag_mem[i] == w.virt_page &&
              (best < 0 || lru_rank[i] < lru_rank[best])) best = i;
        end
        if (best >= 0) begin
          res.hit       = 1'b1;
          res.entry_out = word_mem[best];
          promote_slot(best);
        end
      end
      OP_ADD: begin
        victim = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (lru_rank[i] == RankW'(ENTRIES - 1)) victim = i;
        end
        res.evicted      = live[victim];
        tag_mem[victim]  = w.virt_page;
        word_mem[victim] = w.entry_in;
        live[victim]     = 1'b1;
        promote_slot(victim);
      end
      OP_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          live[i]     = 1'b0;
          lru_rank[i] = RankW'(i);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_mem[i]  = '0;
        word_mem[i] = '0;
        live[i]     = 1'b0;
        lru_rank[i] = RankW'(i);
      end
      awaited_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result word %h", $time, out_word_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (out_word_i.hit !== want.hit) begin
            $display("%0t hit expected %0b actual %0b", $time, want.hit, out_word_i.hit);
            fail_count_o++;
          end
          if (out_word_i.entry_out !== want.entry_out) begin
            $display("%0t entry_out expected %h actual %h", $time, want.entry_out,
                     out_word_i.entry_out);
            fail_count_o++;
          end
          if (out_word_i.evicted !== want.evicted) begin
            $display("%0t evicted expected %0b actual %0b", $time, want.evicted,
                     out_word_i.evicted);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(translate_word(in_word_i));
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== sim/tb_fully_associative_lru_tlb_top.sv =====
// testbench top for the lru translation buffer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_fully_associative_lru_tlb_top;
  import fa_tlb_pkg::*;

  localparam int unsigned TlbEntries     = 16;
  localparam int          PhaseWords     = 670;
  localparam int          PoolDepth      = 24;
  localparam int          RecvHoldCycles = 300;
  localparam int          WatchdogLimit  = 2000;
  localparam logic [OpW-1:0] OP_RESERVED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  int fail_count;
  int pending_cnt;
  int send_idle_pct = 12;
  int recv_idle_pct = 61;
  int stall_cycles;
  bit hold_req = 1'b0;

  logic [PageW-1:0] page_pool[$];

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  fully_associative_lru_tlb_top #(
    .ENTRIES(TlbEntries)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  fully_associative_lru_tlb_checker #(
    .ENTRIES(TlbEntries)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_cnt)
  );

  function automatic in_word_t make_word(logic [OpW-1:0] op, logic [PageW-1:0] page,
                                         logic [EntryW-1:0] entry);
    in_word_t w;
    w.opcode    = op;
    w.virt_page = page;
    w.entry_in  = entry;
    return w;
  endfunction

  function automatic logic [PageW-1:0] any_page();
    return PageW'({$urandom, $urandom});
  endfunction

  function automatic in_word_t random_word();
    int               pick;
    logic [PageW-1:0] page;
    pick = $urandom_range(99);
    page = any_page();
    if (pick < 50) begin
      if (page_pool.size() > 0 && $urandom_range(9) < 8) begin
        page = page_pool[$urandom_range(page_pool.size() - 1)];
        if ($urandom_range(9) == 0) page ^= PageW'(1) << $urandom_range(PageW - 1);
      end
      return make_word(OP_LOOKUP, page, $urandom);
    end else if (pick < 90) begin
      if (page_pool.size() > 0 && $urandom_range(9) < 3)
        page = page_pool[$urandom_range(page_pool.size() - 1)];
      page_pool.push_back(page);
      if (page_pool.size() > PoolDepth) void'(page_pool.pop_front());
      return make_word(OP_ADD, page, $urandom);
    end else if (pick < 95) begin
      return make_word(OP_FLUSH, page, $urandom);
    end
    return make_word(OP_RESERVED, page, $urandom);
  endfunction

  task automatic put_word(input in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RecvHoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [PageW-1:0]  page_v;
    logic [EntryW-1:0] entry_v;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, fill with duplicates and extremes, evict, flush
    put_word(make_word(OP_LOOKUP, '0, '0));
    for (int i = 0; i < TlbEntries; i++) begin
      page_v  = (i == 0) ? '0 : (i >= TlbEntries - 2) ? '1 : any_page();
      entry_v = (i == 0) ? '0 : (i == TlbEntries - 1) ? '1 : EntryW'($urandom);
      put_word(make_word(OP_ADD, page_v, entry_v));
    end
    put_word(make_word(OP_ADD, any_page(), $urandom));
    put_word(make_word(OP_LOOKUP, '0, '1));
    put_word(make_word(OP_LOOKUP, '1, '0));
    put_word(make_word(OP_RESERVED, any_page(), $urandom));
    put_word(make_word(OP_FLUSH, any_page(), $urandom));
    put_word(make_word(OP_LOOKUP, '1, '0));
    put_word(make_word(OP_ADD, any_page(), $urandom));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 61 : 0;
      recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 12 : 0;
      for (int n = 0; n < PhaseWords; n++) begin
        if (ph == 0 && n == 150) hold_req = 1'b1;
        if (ph == 1 && n == 300) drain();
        put_word(random_word());
      end
    end

    drain();
    repeat (6) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== fully_associative_lru_tlb_top.f =====
rtl/fa_tlb_pkg.sv
rtl/fa_tlb_ram.sv
rtl/fa_tlb_ctrl.sv
rtl/fa_tlb_dp.sv
rtl/fully_associative_lru_tlb_top.sv
sim/fully_associative_lru_tlb_checker.sv
sim/tb_fully_associative_lru_tlb_top.sv
